// ----- hw/rtl/isodt_pkg.sv -----
// Types, codes and constants for the ISO 8601 date text to epoch converter.
// Depends on nothing; every other file but isodt_if imports it.
`timescale 1ns / 1ps
package isodt_pkg;

  // Parser position within the date string
  typedef enum logic [4:0] {
    PH_YSTART, PH_YDIG4, PH_YDIG6, PH_AFTER_Y, PH_MON, PH_AFTER_MON,
    PH_DAY, PH_AFTER_DAY, PH_HOUR, PH_HCOLON, PH_MIN, PH_AFTER_MIN,
    PH_SEC, PH_AFTER_SEC, PH_MS, PH_AFTER_MS, PH_ZH, PH_ZCOLON, PH_ZM,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    ZONE_NONE, ZONE_UTC, ZONE_PLUS, ZONE_MINUS
  } zone_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_PREP, BK_DIV, BK_DAYS, BK_SCALE, BK_DONE
  } back_state_t;

  // One parsed string, handed from the parser to the converter
  typedef struct packed {
    logic               ok;
    logic signed [20:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         milli;
    logic               hours_seen;
    zone_t              zone;
    logic [4:0]         zone_hours;
    logic [5:0]         zone_minutes;
  } date_rec_t;

  // Bias that keeps the March-based year positive; a multiple of 400
  localparam logic [20:0] YEAR_BIAS   = 21'd1000400;
  // ceil(2^24 / 25): exact quotient by 25 for values below 2^19
  localparam logic [19:0] RECIP25     = 20'd671089;
  // 719468 plus the day count that YEAR_BIAS adds
  localparam logic [31:0] DAY_BIAS    = 32'd366108065;
  localparam logic [26:0] MS_PER_DAY  = 27'd86400000;

  // Days from 1 March to the first of the month
  function automatic logic [8:0] doy_of_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/isodt_if.sv -----
// Valid/ready channel interfaces: date characters in, epoch results out.
// No dependencies.
`timescale 1ns / 1ps
interface isodt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  modport source (output valid, text_char, last_char, input ready);
  modport sink (input valid, text_char, last_char, output ready);
endinterface

interface isodt_result_if;
  logic               valid;
  logic               ready;
  logic               date_valid;
  logic signed [55:0] epoch_ms;
  modport source (output valid, date_valid, epoch_ms, input ready);
  modport sink (input valid, date_valid, epoch_ms, output ready);
endinterface

// ----- hw/rtl/isodt_front.sv -----
// Character parser: one character per cycle while take is high, emits a parsed
// record at the last character. Depends on isodt_pkg.
`timescale 1ns / 1ps
module isodt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          text_char,
  input  logic                last_char,
  output logic                push,
  output isodt_pkg::date_rec_t rec
);
  import isodt_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [19:0]        acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic signed [20:0] year_r, year_nxt;
  logic [3:0]         mon_r, mon_nxt;
  logic [4:0]         day_r, day_nxt;
  logic [4:0]         hour_r, hour_nxt;
  logic [5:0]         min_r, min_nxt;
  logic [5:0]         sec_r, sec_nxt;
  logic [9:0]         ms_r, ms_nxt;
  logic               hseen_r, hseen_nxt;
  zone_t              zone_r, zone_nxt;
  logic [4:0]         zh_r, zh_nxt;
  logic [5:0]         zm_r, zm_nxt;
  logic               fail_r, fail_nxt;

  logic        is_dig;
  logic [3:0]  dval;
  logic [19:0] acc_n;
  logic [2:0]  need;
  logic        dig_done;
  logic        digit_phase;
  logic        accepting;

  assign is_dig = (text_char >= 8'h30) && (text_char <= 8'h39);
  assign dval   = text_char[3:0];
  assign acc_n  = 20'((acc_r * 20'd10) + {16'd0, dval});

  // Digits needed to close the field under way
  always_comb begin
    case (phase_r)
      PH_YSTART, PH_YDIG4: need = 3'd4;
      PH_YDIG6:            need = 3'd6;
      PH_MS:               need = 3'd3;
      default:             need = 3'd2;
    endcase
  end
  assign dig_done = is_dig && ((cnt_r + 3'd1) == need);

  // Next parse state for one character
  always_comb begin
    phase_nxt = phase_r; cnt_nxt = cnt_r; acc_nxt = acc_r; neg_nxt = neg_r;
    year_nxt = year_r; mon_nxt = mon_r; day_nxt = day_r; hour_nxt = hour_r;
    min_nxt = min_r; sec_nxt = sec_r; ms_nxt = ms_r; hseen_nxt = hseen_r;
    zone_nxt = zone_r; zh_nxt = zh_r; zm_nxt = zm_r; fail_nxt = fail_r;
    digit_phase = 1'b0;
    if (!fail_r) begin
      case (phase_r)
        PH_YSTART: begin
          if (text_char == "+") begin
            phase_nxt = PH_YDIG6;
          end else if (text_char == "-") begin
            neg_nxt = 1'b1;
            phase_nxt = PH_YDIG6;
          end else begin
            phase_nxt = PH_YDIG4;
            digit_phase = 1'b1;
          end
        end
        PH_YDIG4, PH_YDIG6: begin
          digit_phase = 1'b1;
          if (dig_done) begin
            year_nxt = neg_r ? -$signed({1'b0, acc_n}) : $signed({1'b0, acc_n});
            phase_nxt = PH_AFTER_Y;
          end
        end
        PH_AFTER_Y, PH_AFTER_MON: begin
          if (text_char == "-")
            phase_nxt = (phase_r == PH_AFTER_Y) ? PH_MON : PH_DAY;
          else if (text_char == "T")
            phase_nxt = PH_HOUR;
          else
            fail_nxt = 1'b1;
        end
        PH_MON: begin
          digit_phase = 1'b1;
          if (dig_done) begin
            if (acc_n < 20'd1 || acc_n > 20'd12) fail_nxt = 1'b1;
            mon_nxt = acc_n[3:0];
            phase_nxt = PH_AFTER_MON;
          end
        end
        PH_DAY: begin
          digit_phase = 1'b1;
          if (dig_done) begin
            if (acc_n < 20'd1 || acc_n > 20'd31) fail_nxt = 1'b1;
            day_nxt = acc_n[4:0];
            phase_nxt = PH_AFTER_DAY;
          end
        end
        PH_AFTER_DAY: begin
          if (text_char == "T") phase_nxt = PH_HOUR;
          else fail_nxt = 1'b1;
        end
        PH_HOUR, PH_ZH: begin
          digit_phase = 1'b1;
          if (dig_done) begin
            if (acc_n > 20'd24) fail_nxt = 1'b1;
            if (phase_r == PH_HOUR) begin
              hour_nxt = acc_n[4:0];
              phase_nxt = PH_HCOLON;
            end else begin
              zh_nxt = acc_n[4:0];
              phase_nxt = PH_ZCOLON;
            end
          end
        end
        PH_HCOLON, PH_ZCOLON: begin
          if (text_char == ":") phase_nxt = (phase_r == PH_HCOLON) ? PH_MIN : PH_ZM;
          else fail_nxt = 1'b1;
        end
        PH_MIN, PH_ZM, PH_SEC: begin
          digit_phase = 1'b1;
          if (dig_done) begin
            if (acc_n > 20'd59) fail_nxt = 1'b1;
            if (phase_r == PH_MIN) begin
              min_nxt = acc_n[5:0];
              hseen_nxt = 1'b1;
              phase_nxt = PH_AFTER_MIN;
            end else if (phase_r == PH_ZM) begin
              zm_nxt = acc_n[5:0];
              phase_nxt = PH_END;
            end else begin
              sec_nxt = acc_n[5:0];
              phase_nxt = PH_AFTER_SEC;
            end
          end
        end
        PH_MS: begin
          digit_phase = 1'b1;
          if (dig_done) begin
            ms_nxt = acc_n[9:0];
            phase_nxt = PH_AFTER_MS;
          end
        end
        PH_AFTER_MIN, PH_AFTER_SEC, PH_AFTER_MS: begin
          if (phase_r == PH_AFTER_MIN && text_char == ":") begin
            phase_nxt = PH_SEC;
          end else if (phase_r == PH_AFTER_SEC && text_char == ".") begin
            phase_nxt = PH_MS;
          end else if (text_char == "+") begin
            zone_nxt = ZONE_PLUS;
            phase_nxt = PH_ZH;
          end else if (text_char == "-") begin
            zone_nxt = ZONE_MINUS;
            phase_nxt = PH_ZH;
          end else if (text_char == "Z") begin
            zone_nxt = ZONE_UTC;
            phase_nxt = PH_END;
          end else begin
            fail_nxt = 1'b1;
          end
        end
        default: fail_nxt = 1'b1;
      endcase
      // Shared digit accumulator
      if (digit_phase) begin
        if (!is_dig) begin
          fail_nxt = 1'b1;
        end else if (dig_done) begin
          acc_nxt = '0;
          cnt_nxt = '0;
        end else begin
          acc_nxt = acc_n;
          cnt_nxt = cnt_r + 3'd1;
        end
      end
    end
  end

  always_comb begin
    case (phase_nxt)
      PH_AFTER_Y, PH_AFTER_MON, PH_AFTER_DAY, PH_AFTER_MIN, PH_AFTER_SEC,
      PH_AFTER_MS, PH_END: accepting = 1'b1;
      default:             accepting = 1'b0;
    endcase
  end

  // Record handed on at the end of a string
  assign push = take && last_char;
  always_comb begin
    rec.ok           = !fail_nxt && accepting;
    rec.year         = year_nxt;
    rec.month        = mon_nxt;
    rec.day          = day_nxt;
    rec.hour         = hour_nxt;
    rec.minute       = min_nxt;
    rec.second       = sec_nxt;
    rec.milli        = ms_nxt;
    rec.hours_seen   = hseen_nxt;
    rec.zone         = zone_nxt;
    rec.zone_hours   = zh_nxt;
    rec.zone_minutes = zm_nxt;
  end

  // Parse state; cleared at reset and after each string
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      phase_r <= PH_YSTART; cnt_r <= '0; acc_r <= '0; neg_r <= 1'b0;
      year_r <= '0; mon_r <= 4'd1; day_r <= 5'd1; hour_r <= '0;
      min_r <= '0; sec_r <= '0; ms_r <= '0; hseen_r <= 1'b0;
      zone_r <= ZONE_NONE; zh_r <= '0; zm_r <= '0; fail_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; acc_r <= acc_nxt; neg_r <= neg_nxt;
      year_r <= year_nxt; mon_r <= mon_nxt; day_r <= day_nxt; hour_r <= hour_nxt;
      min_r <= min_nxt; sec_r <= sec_nxt; ms_r <= ms_nxt; hseen_r <= hseen_nxt;
      zone_r <= zone_nxt; zh_r <= zh_nxt; zm_r <= zm_nxt; fail_r <= fail_nxt;
    end
  end

endmodule

// ----- hw/rtl/isodt_fifo.sv -----
// Short record queue between the parser and the converter.
// Depends on isodt_pkg.
`timescale 1ns / 1ps
module isodt_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  isodt_pkg::date_rec_t wr_rec,
  input  logic                 pop,
  output isodt_pkg::date_rec_t rd_rec,
  output logic                 full,
  output logic                 empty
);
  import isodt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  date_rec_t         mem_r [DEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r;

  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_rec = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_rec;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ----- hw/rtl/isodt_back.sv -----
// Epoch converter: days-from-civil and millisecond scaling over five steps,
// with an output register. Depends on isodt_pkg.
`timescale 1ns / 1ps
module isodt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rec_avail,
  input  isodt_pkg::date_rec_t rec,
  output logic                 pop,
  input  logic signed [10:0]   local_offset,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 res_date_valid,
  output logic signed [55:0]   res_epoch_ms
);
  import isodt_pkg::*;

  back_state_t state_r, state_nxt;

  date_rec_t          rec_r;
  logic [20:0]        ybias_r;
  logic [8:0]         dayoff_r;
  logic signed [19:0] tod_s_r;
  logic [14:0]        q100_r;
  logic [29:0]        y365_r;
  logic signed [28:0] tod_ms_r;
  logic signed [31:0] days_r;
  logic signed [55:0] dms_r;
  logic               ovld_r;
  logic               odv_r;
  logic signed [55:0] oms_r;

  logic               out_free;
  logic signed [21:0] ymar;
  logic [17:0]        base_s;
  logic [17:0]        zoff_s;
  logic signed [19:0] adj_s;
  logic [38:0]        qprod;
  logic signed [55:0] ms_sum;

  assign out_free = !ovld_r || res_ready;
  assign pop      = (state_r == BK_IDLE) && rec_avail;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (rec_avail) state_nxt = BK_PREP;
      BK_PREP:  state_nxt = BK_DIV;
      BK_DIV:   state_nxt = BK_DAYS;
      BK_DAYS:  state_nxt = BK_SCALE;
      BK_SCALE: state_nxt = BK_DONE;
      BK_DONE:  if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // Prep: March-based year, day of year and time of day in seconds
  assign ymar   = 22'(rec_r.year) - ((rec_r.month <= 4'd2) ? 22'sd1 : 22'sd0);
  assign base_s = 18'(rec_r.hour * 17'd3600) + 18'(rec_r.minute * 12'd60)
                  + 18'(rec_r.second);
  assign zoff_s = 18'((rec_r.zone_hours * 11'd60 + 11'(rec_r.zone_minutes)) * 18'd60);
  always_comb begin
    case (rec_r.zone)
      ZONE_MINUS: adj_s = $signed({2'b00, zoff_s});
      ZONE_PLUS:  adj_s = -$signed({2'b00, zoff_s});
      ZONE_NONE:  adj_s = rec_r.hours_seen ? 20'(-(local_offset * 18'sd60)) : '0;
      default:    adj_s = '0;
    endcase
  end

  // Divide by 100 as a shift by two and a reciprocal multiply by 1/25
  assign qprod  = {20'd0, ybias_r[20:2]} * {19'd0, RECIP25};
  assign ms_sum = dms_r + 56'(tod_ms_r);

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: if (rec_avail) rec_r <= rec;
      BK_PREP: begin
        ybias_r  <= 21'(ymar + $signed({1'b0, YEAR_BIAS}));
        dayoff_r <= doy_of_month(rec_r.month) + 9'(rec_r.day) - 9'd1;
        tod_s_r  <= $signed({2'b00, base_s}) + adj_s;
      end
      BK_DIV: begin
        q100_r   <= qprod[38:24];
        y365_r   <= 30'(ybias_r * 30'd365);
        tod_ms_r <= 29'(tod_s_r * 29'sd1000) + $signed({19'd0, rec_r.milli});
      end
      BK_DAYS: begin
        days_r <= $signed(32'(y365_r) + 32'(ybias_r[20:2]) - 32'(q100_r)
                  + 32'(q100_r[14:2]) + 32'(dayoff_r) - DAY_BIAS);
      end
      BK_SCALE: dms_r <= 56'(days_r * $signed({1'b0, MS_PER_DAY}));
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (state_r == BK_DONE && out_free) begin
      ovld_r <= 1'b1;
    end else if (res_ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_DONE && out_free) begin
      odv_r <= rec_r.ok;
      oms_r <= rec_r.ok ? ms_sum : '0;
    end
  end

  assign res_valid      = ovld_r;
  assign res_date_valid = odv_r;
  assign res_epoch_ms   = oms_r;

endmodule

// ----- hw/rtl/iso8601_date_text_to_epoch_ms.sv -----
// Top level of the ISO 8601 date text to epoch converter.
// Depends on isodt_pkg, isodt_if, isodt_front, isodt_fifo, isodt_back.
`timescale 1ns / 1ps
// Takes one character per transaction on in_chan, the last one marked by
// last_char, and gives one result per string on out_chan: a valid flag and
// signed milliseconds since 1970-01-01 UTC (zero when the string is invalid).
// The parser takes a character every cycle. At the end of a string the parsed
// fields go into a record queue of FIFO_DEPTH entries; the converter works
// through each string in turn (take, prep, divide, day sum, scale, output),
// so while results are taken strings of six or more characters stream at
// one character a cycle. The input stalls only while the record queue is full.
// cfg_wdata sets the local offset in minutes used for times with no zone;
// write it only while the block is idle.
module iso8601_date_text_to_epoch_ms #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  isodt_char_if.sink         in_chan,
  isodt_result_if.source     out_chan,
  input  logic               cfg_we,
  input  logic signed [10:0] cfg_wdata
);
  import isodt_pkg::*;

  logic signed [10:0] local_offset_r;
  logic               take;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  date_rec_t          wr_rec;
  date_rec_t          rd_rec;

  // Offset register
  always_ff @(posedge clk) begin
    if (!rst_n)      local_offset_r <= '0;
    else if (cfg_we) local_offset_r <= cfg_wdata;
  end

  assign in_chan.ready = !q_full;
  assign take          = in_chan.valid && !q_full;

  isodt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .text_char (in_chan.text_char),
    .last_char (in_chan.last_char),
    .push      (push),
    .rec       (wr_rec)
  );

  isodt_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .full   (q_full),
    .empty  (q_empty)
  );

  isodt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rec_avail      (!q_empty),
    .rec            (rd_rec),
    .pop            (pop),
    .local_offset   (local_offset_r),
    .res_valid      (out_chan.valid),
    .res_ready      (out_chan.ready),
    .res_date_valid (out_chan.date_valid),
    .res_epoch_ms   (out_chan.epoch_ms)
  );

endmodule

// ----- sim/isodt_checker.sv -----
// Checker for the ISO 8601 date text to epoch converter: watches both channels
// and the offset register, predicts each result and compares. Depends on
// isodt_pkg and isodt_if.
`timescale 1ns / 1ps
module isodt_checker (
  input  logic               clk,
  input  logic               rst_n,
  isodt_char_if              in_chan,
  isodt_result_if            out_chan,
  input  logic               cfg_we,
  input  logic signed [10:0] cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  import isodt_pkg::*;

  typedef struct {
    bit          ok;
    logic [55:0] ms;
  } epoch_res_t;

  epoch_res_t epoch_q[$];

  // Shadow of the parser and the offset register
  logic signed [10:0] offset_min;
  phase_t             ph;
  logic [2:0]         n_dig;
  logic [19:0]        accum;
  bit                 yneg;
  logic signed [20:0] year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;
  logic [9:0]         milli;
  bit                 hseen;
  zone_t              zone;
  logic [4:0]         zhours;
  logic [5:0]         zmins;
  bit                 failed;

  function automatic void clear_date();
    ph = PH_YSTART; n_dig = 0; accum = 0; yneg = 0; year = 0;
    month = 1; day = 1; hour = 0; minute = 0; second = 0; milli = 0;
    hseen = 0; zone = ZONE_NONE; zhours = 0; zmins = 0; failed = 0;
  endfunction

  // Returns the field once enough digits are in, else -1
  function automatic int digit(logic [7:0] c, int need);
    int v;
    if (c < "0" || c > "9") begin
      failed = 1;
      return -1;
    end
    accum = accum * 10 + (c - "0");
    n_dig = n_dig + 1;
    if (n_dig < need) return -1;
    v = accum;
    accum = 0;
    n_dig = 0;
    return v;
  endfunction

  function automatic void zone_mark(logic [7:0] c);
    if (c == "+") begin
      zone = ZONE_PLUS; ph = PH_ZH;
    end else if (c == "-") begin
      zone = ZONE_MINUS; ph = PH_ZH;
    end else if (c == "Z") begin
      zone = ZONE_UTC; ph = PH_END;
    end else failed = 1;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    int v;
    case (ph)
      PH_YSTART: begin
        if (c == "+") ph = PH_YDIG6;
        else if (c == "-") begin
          yneg = 1; ph = PH_YDIG6;
        end else begin
          ph = PH_YDIG4;
          void'(digit(c, 4));
        end
      end
      PH_YDIG4, PH_YDIG6: begin
        v = digit(c, (ph == PH_YDIG4) ? 4 : 6);
        if (v >= 0) begin
          year = yneg ? -v : v;
          ph = PH_AFTER_Y;
        end
      end
      PH_AFTER_Y, PH_AFTER_MON: begin
        if (c == "-") ph = (ph == PH_AFTER_Y) ? PH_MON : PH_DAY;
        else if (c == "T") ph = PH_HOUR;
        else failed = 1;
      end
      PH_MON: begin
        v = digit(c, 2);
        if (v >= 0) begin
          if (v < 1 || v > 12) failed = 1;
          month = v[3:0]; ph = PH_AFTER_MON;
        end
      end
      PH_DAY: begin
        v = digit(c, 2);
        if (v >= 0) begin
          if (v < 1 || v > 31) failed = 1;
          day = v[4:0]; ph = PH_AFTER_DAY;
        end
      end
      PH_AFTER_DAY: begin
        if (c == "T") ph = PH_HOUR;
        else failed = 1;
      end
      PH_HOUR, PH_ZH: begin
        v = digit(c, 2);
        if (v >= 0) begin
          if (v > 24) failed = 1;
          if (ph == PH_HOUR) begin
            hour = v[4:0]; ph = PH_HCOLON;
          end else begin
            zhours = v[4:0]; ph = PH_ZCOLON;
          end
        end
      end
      PH_HCOLON, PH_ZCOLON: begin
        if (c == ":") ph = (ph == PH_HCOLON) ? PH_MIN : PH_ZM;
        else failed = 1;
      end
      PH_MIN, PH_ZM, PH_SEC: begin
        v = digit(c, 2);
        if (v >= 0) begin
          if (v > 59) failed = 1;
          if (ph == PH_MIN) begin
            minute = v[5:0]; hseen = 1; ph = PH_AFTER_MIN;
          end else if (ph == PH_ZM) begin
            zmins = v[5:0]; ph = PH_END;
          end else begin
            second = v[5:0]; ph = PH_AFTER_SEC;
          end
        end
      end
      PH_AFTER_MIN: begin
        if (c == ":") ph = PH_SEC;
        else zone_mark(c);
      end
      PH_AFTER_SEC: begin
        if (c == ".") ph = PH_MS;
        else zone_mark(c);
      end
      PH_MS: begin
        v = digit(c, 3);
        if (v >= 0) begin
          milli = v[9:0]; ph = PH_AFTER_MS;
        end
      end
      PH_AFTER_MS: zone_mark(c);
      default: failed = 1;
    endcase
  endfunction

  // Proleptic Gregorian day number, 1970-01-01 is day 0
  function automatic longint civil_days(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = ((y >= 0) ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic epoch_res_t finish_date();
    epoch_res_t r;
    longint secs, zoff;
    r.ok = !failed && (ph inside {PH_AFTER_Y, PH_AFTER_MON, PH_AFTER_DAY,
           PH_AFTER_MIN, PH_AFTER_SEC, PH_AFTER_MS, PH_END});
    r.ms = '0;
    if (r.ok) begin
      secs = civil_days(year, month, 1) + day - 1;
      secs = secs * 86400 + hour * 3600 + minute * 60 + second;
      zoff = (longint'(zhours) * 60 + zmins) * 60;
      if (zone == ZONE_MINUS) secs += zoff;
      else if (zone == ZONE_PLUS) secs -= zoff;
      else if (zone == ZONE_NONE && hseen) secs -= longint'(offset_min) * 60;
      r.ms = secs * 1000 + milli;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    epoch_res_t e;
    if (!rst_n) begin
      offset_min = 0;
      clear_date();
      epoch_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) offset_min = cfg_wdata;
      // Character transaction
      if (in_chan.valid && in_chan.ready) begin
        if (!failed) parse_char(in_chan.text_char);
        if (in_chan.last_char) begin
          epoch_q.push_back(finish_date());
          clear_date();
        end
      end
      // Result transaction
      if (out_chan.valid && out_chan.ready) begin
        if (epoch_q.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] result with none expected: valid %0b ms %0d", $realtime,
                     out_chan.date_valid, out_chan.epoch_ms);
          fail_count <= fail_count + 1;
        end else begin
          e = epoch_q.pop_front();
          if (out_chan.date_valid !== e.ok || out_chan.epoch_ms !== e.ms) begin
            if (fail_count < 10)
              $display("[%0t] mismatch: expected valid %0b ms %0d, got valid %0b ms %0d",
                       $realtime, e.ok, $signed(e.ms), out_chan.date_valid,
                       out_chan.epoch_ms);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= epoch_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the converter testbench: clock, reset, date string stimulus, result
// back-pressure, offset register phases and the verdict. Depends on isodt_pkg,
// isodt_if, isodt_checker and the converter RTL.
`timescale 1ns / 1ps
module testbench;
  import isodt_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 20;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic signed [10:0] cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 chars_sent;
  int                 idle_cycles;
  bit                 no_gaps;
  int                 stall_left;

  isodt_char_if   in_chan ();
  isodt_result_if out_chan ();

  iso8601_date_text_to_epoch_ms dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  isodt_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Result back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n)
      idle_cycles <= 0;
    else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic last);
    int gap;
    bit rdy;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.text_char <= c;
    in_chan.last_char <= last;
    do begin
      @(negedge clk);
      rdy = in_chan.ready;
      @(posedge clk);
    end while (!rdy);
    chars_sent++;
  endtask

  task automatic send_text(byte unsigned txt[$]);
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
  endtask

  function automatic void to_bytes(string s, ref byte unsigned q[$]);
    q.delete();
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Well-formed date text with random fields, some out of range
  function automatic string random_date();
    string s;
    int z;
    if ($urandom_range(0, 2) == 0) s = $sformatf("%04d", $urandom_range(0, 9999));
    else s = $sformatf("%s%06d", $urandom_range(0, 1) ? "+" : "-",
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 3)
                                                 : $urandom_range(0, 999999));
    if ($urandom_range(0, 9) < 8) begin
      s = {s, $sformatf("-%02d", $urandom_range(0, 9) ? $urandom_range(1, 12)
                                                      : $urandom_range(0, 99))};
      if ($urandom_range(0, 9) < 7)
        s = {s, $sformatf("-%02d", $urandom_range(0, 9) ? $urandom_range(1, 31)
                                                        : $urandom_range(0, 99))};
    end
    if ($urandom_range(0, 9) < 7) begin
      s = {s, $sformatf("T%02d:%02d",
                        $urandom_range(0, 9) ? $urandom_range(0, 24) : $urandom_range(0, 99),
                        $urandom_range(0, 9) ? $urandom_range(0, 59) : $urandom_range(0, 99))};
      if ($urandom_range(0, 9) < 6) begin
        s = {s, $sformatf(":%02d", $urandom_range(0, 9) ? $urandom_range(0, 59)
                                                        : $urandom_range(0, 99))};
        if ($urandom_range(0, 1)) s = {s, $sformatf(".%03d", $urandom_range(0, 999))};
      end
      z = $urandom_range(0, 3);
      if (z == 1) s = {s, "Z"};
      else if (z > 1)
        s = {s, $sformatf("%s%02d:%02d", (z == 2) ? "+" : "-",
                          $urandom_range(0, 9) ? $urandom_range(0, 24) : $urandom_range(0, 99),
                          $urandom_range(0, 9) ? $urandom_range(0, 59) : $urandom_range(0, 99))};
    end
    return s;
  endfunction

  task automatic random_strings(int n_chars);
    byte unsigned q[$];
    int stop, k;
    stop = chars_sent + n_chars;
    while (chars_sent < stop) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        // Noise of arbitrary bytes
        q.delete();
        repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
      end else begin
        to_bytes(random_date(), q);
        if (k < 18) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        else if (k < 24 && q.size() > 1) q = q[0:$urandom_range(0, q.size() - 2)];
      end
      send_text(q);
    end
  endtask

  // Wait for the converter to drain, then set a new local offset
  task automatic set_offset(logic signed [10:0] v);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  string directed[$] = '{
    "0000", "1970", "+999999-12-31T24:59:59.999-24:59",
    "-999999-01-01T00:00Z", "-000000-03-01", "2000-02-29T12:00",
    "2023-02-31T23:59:59", "2024-13-01", "2024-01-32", "2024-00-10",
    "2024-01-01T25:00", "2024-01-01T10:60", "2024-01-01T10:00:60",
    "2024-06-15T08:30+05:30", "2024-06-15T08:30:00.5", "2024-", "2024-06T",
    "1970-01-01TZ", "2024-06-15T08:30+25:00", "x", "12", "2024-06-15T08:30Zq",
    "+1970", "2024-06-15T08"
  };

  initial begin
    byte unsigned q[$];
    logic signed [10:0] offsets[$] = '{11'sd900, -11'sd900, -11'sd1024, 11'sd1023, 11'sd0};
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_chan.valid     = 1'b0;
    in_chan.text_char = '0;
    in_chan.last_char = 1'b0;
    chars_sent        = 0;
    no_gaps           = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings at the reset offset, then with a positive offset
    foreach (directed[i]) begin
      to_bytes(directed[i], q);
      send_text(q);
    end
    set_offset(11'sd330);
    foreach (directed[i]) begin
      to_bytes(directed[i], q);
      send_text(q);
    end

    // Random strings over several offsets, one phase with no idling
    foreach (offsets[i]) begin
      set_offset(offsets[i]);
      no_gaps = (i == 1);
      random_strings(110);
    end
    set_offset(11'($urandom_range(0, 2047)));
    random_strings(150);
    in_chan.valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
